// ===== rtl/dbal_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dbal_pkg;

  // Default build parameters.
  localparam int FRACTION_BITS_DEF = 16;
  localparam int COUNT_WIDTH_DEF   = 32;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_K  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_B  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MPC     = 3'd3;

  localparam logic signed [15:0] GAIN_K_RST  = 16'sd0;
  localparam logic signed [15:0] GAIN_B_RST  = 16'sd0;
  localparam logic signed [15:0] RATIO_C_RST = 16'sd4096;
  localparam logic [23:0]        MPC_RST     = 24'd112003;

  // Shared multiplier operand and product widths.
  localparam int MUL_AW = 34;
  localparam int MUL_BW = 27;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // Velocity to drive mapping: slopes in signed Q11.16, offsets in Q8.24.
  localparam logic signed [MUL_BW-1:0] SLOPE_L = 27'sd44242698;
  localparam logic signed [MUL_BW-1:0] SLOPE_R = 27'sd45583565;
  localparam logic [63:0] OFFS_L_Q24 = 64'd1338939277;
  localparam logic [63:0] OFFS_R_Q24 = 64'd1115080884;

  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] left_ticks;
    logic signed [31:0] right_ticks;
    logic [31:0]        time_ms;
  } in_item_t;

  typedef struct packed {
    logic               is_correction;
    logic signed [31:0] pwm_left;
    logic signed [31:0] pwm_right;
    logic               time_fault;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_MUL_L, S_MUL_R, S_SCALE, S_DIV_INIT, S_DIV, S_VEL,
    S_MUL_C, S_ERR, S_MUL_K, S_MUL_B, S_DV, S_ADJ, S_PWM_L, S_PWM_R,
    S_PWM_FIN, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_REF, OP_DIFF, OP_MUL_L, OP_MUL_R, OP_SCALE, OP_DIV_INIT,
    OP_DIV_STEP, OP_VEL, OP_MUL_C, OP_ERR, OP_MUL_K, OP_MUL_B, OP_DV,
    OP_ADJ, OP_PWM_L, OP_PWM_R, OP_PWM_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   load_in;
    logic   load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic kind;
    logic fault;
  } dp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Offset rounded half up from 24 fraction bits down to 24 - s.
  function automatic logic signed [63:0] pwm_offset(input int s, input logic [63:0] off24);
    logic [63:0] half;
    logic [63:0] sum;
    half = (s == 0) ? 64'd0 : (64'd1 << (s - 1));
    sum  = off24 + half;
    return $signed(sum >> s);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dbal_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface dbal_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/dbal_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dbal_dp #(
  parameter int FRACTION_BITS = dbal_pkg::FRACTION_BITS_DEF,
  parameter int COUNT_WIDTH   = dbal_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [dbal_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dbal_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  dbal_pkg::dp_cmd_t                   cmd,
  output dbal_pkg::dp_stat_t                  stat,
  input  dbal_pkg::in_item_t                  item_in,
  output dbal_pkg::out_item_t                 item_out
);
  import dbal_pkg::*;

  localparam int SHIFT = 24 - FRACTION_BITS;
  localparam int QW    = 32 + SHIFT;        // quotient bits kept by the divider
  localparam int MDW   = COUNT_WIDTH + 1;   // count difference magnitude
  localparam int NRW   = MDW + 24;          // magnitude times metres per count
  localparam int NW    = NRW + 10;          // scaled by 1000
  localparam int HW    = NW - QW;
  localparam int CMPW  = (HW > 32) ? HW : 32;
  localparam logic signed [63:0] OFF_L = pwm_offset(SHIFT, OFFS_L_Q24);
  localparam logic signed [63:0] OFF_R = pwm_offset(SHIFT, OFFS_R_Q24);

  // Configuration registers.
  logic signed [15:0] gain_k;
  logic signed [15:0] gain_b;
  logic signed [15:0] ratio_c;
  logic [23:0]        mpc;

  // Reference point and loop memory.
  logic signed [COUNT_WIDTH-1:0] ref_left;
  logic signed [COUNT_WIDTH-1:0] ref_right;
  logic [31:0]                   ref_time;
  logic signed [31:0]            last_error;

  // Captured item.
  logic                          kind_r;
  logic signed [COUNT_WIDTH-1:0] lt_r;
  logic signed [COUNT_WIDTH-1:0] rt_r;
  logic [31:0]                   time_r;

  // Working registers.
  logic [31:0]             dt;
  logic [MDW-1:0]          md_l;
  logic [MDW-1:0]          md_r;
  logic                    neg_l;
  logic                    neg_r;
  logic                    fault_r;
  logic [NW-1:0]           num_l;
  logic [NW-1:0]           num_r;
  logic [31:0]             rem_l;
  logic [31:0]             rem_r;
  logic [QW-1:0]           lo_l;
  logic [QW-1:0]           lo_r;
  logic [QW-1:0]           q_l;
  logic [QW-1:0]           q_r;
  logic                    ovf_l;
  logic                    ovf_r;
  logic signed [31:0]      vl;
  logic signed [31:0]      vr;
  logic signed [31:0]      err;
  logic signed [32:0]      derr;
  logic signed [48:0]      pk;
  logic signed [31:0]      dv;
  logic signed [31:0]      pwm_l;
  logic signed [31:0]      pwm_r;
  logic signed [MUL_PW-1:0] mul_p;

  // Combinational signals.
  logic [31:0]              dt_c;
  logic signed [MDW-1:0]    d_l;
  logic signed [MDW-1:0]    d_r;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic [CMPW-1:0]          hi_l;
  logic [CMPW-1:0]          hi_r;
  logic [CMPW-1:0]          dt_ext;
  logic [32:0]              r2_l;
  logic [32:0]              r2_r;
  logic [32:0]              dt33;
  logic                     ge_l;
  logic                     ge_r;
  logic signed [63:0]       pd_sum;

  function automatic logic [NW-1:0] x1000(input logic [NRW-1:0] v);
    logic [NW-1:0] w;
    w = NW'(v);
    return (w << 10) - (w << 4) - (w << 3);
  endfunction

  function automatic logic signed [31:0] to_vel(input logic neg, input logic ovf,
                                               input logic [31:0] m);
    logic signed [31:0] r;
    if (ovf || m[31]) begin
      r = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = neg ? -$signed(m) : $signed(m);
    end
    return r;
  endfunction

  assign dt_c       = time_r - ref_time;
  assign stat.kind  = kind_r;
  assign stat.fault = (dt_c == 32'd0);

  assign d_l = $signed({lt_r[COUNT_WIDTH-1], lt_r}) - $signed({ref_left[COUNT_WIDTH-1], ref_left});
  assign d_r = $signed({rt_r[COUNT_WIDTH-1], rt_r}) - $signed({ref_right[COUNT_WIDTH-1], ref_right});

  assign hi_l   = CMPW'(num_l[NW-1:QW]);
  assign hi_r   = CMPW'(num_r[NW-1:QW]);
  assign dt_ext = CMPW'(dt);
  assign dt33   = {1'b0, dt};
  assign r2_l   = {rem_l, lo_l[QW-1]};
  assign r2_r   = {rem_r, lo_r[QW-1]};
  assign ge_l   = (r2_l >= dt33);
  assign ge_r   = (r2_r >= dt33);

  assign pd_sum = -64'(pk) - 64'(mul_p);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_L: begin
        mul_a = $signed({{(MUL_AW-MDW){1'b0}}, md_l});
        mul_b = $signed({{(MUL_BW-24){1'b0}}, mpc});
      end
      OP_MUL_R: begin
        mul_a = $signed({{(MUL_AW-MDW){1'b0}}, md_r});
        mul_b = $signed({{(MUL_BW-24){1'b0}}, mpc});
      end
      OP_MUL_C: begin
        mul_a = MUL_AW'(vl);
        mul_b = MUL_BW'(ratio_c);
      end
      OP_MUL_K: begin
        mul_a = MUL_AW'(err);
        mul_b = MUL_BW'(gain_k);
      end
      OP_MUL_B: begin
        mul_a = MUL_AW'(derr);
        mul_b = MUL_BW'(gain_b);
      end
      OP_PWM_L: begin
        mul_a = MUL_AW'(vl);
        mul_b = SLOPE_L;
      end
      OP_PWM_R: begin
        mul_a = MUL_AW'(vr);
        mul_b = SLOPE_R;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Configuration and persistent state.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_k     <= GAIN_K_RST;
      gain_b     <= GAIN_B_RST;
      ratio_c    <= RATIO_C_RST;
      mpc        <= MPC_RST;
      ref_left   <= '0;
      ref_right  <= '0;
      ref_time   <= '0;
      last_error <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GAIN_K:  gain_k  <= cfg_data[15:0];
          REG_GAIN_B:  gain_b  <= cfg_data[15:0];
          REG_RATIO_C: ratio_c <= cfg_data[15:0];
          REG_MPC:     mpc     <= cfg_data[23:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_REF) begin
        ref_left  <= lt_r;
        ref_right <= rt_r;
        ref_time  <= time_r;
      end
      if (cmd.op == OP_MUL_K) begin
        last_error <= err;
      end
    end
  end

  // Datapath payload registers.
  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    if (cmd.load_in) begin
      kind_r <= item_in.kind;
      lt_r   <= item_in.left_ticks[COUNT_WIDTH-1:0];
      rt_r   <= item_in.right_ticks[COUNT_WIDTH-1:0];
      time_r <= item_in.time_ms;
    end
    if (cmd.load_out) begin
      item_out.is_correction <= kind_r;
      item_out.pwm_left      <= kind_r ? pwm_l : 32'sd0;
      item_out.pwm_right     <= kind_r ? pwm_r : 32'sd0;
      item_out.time_fault    <= kind_r & fault_r;
    end
    unique case (cmd.op)
      OP_REF: begin
        fault_r <= 1'b0;
      end
      OP_DIFF: begin
        dt      <= dt_c;
        fault_r <= stat.fault;
        neg_l   <= d_l[MDW-1];
        neg_r   <= d_r[MDW-1];
        md_l    <= d_l[MDW-1] ? MDW'(-d_l) : MDW'(d_l);
        md_r    <= d_r[MDW-1] ? MDW'(-d_r) : MDW'(d_r);
        vl      <= '0;
        vr      <= '0;
      end
      OP_MUL_R: begin
        num_l <= x1000(mul_p[NRW-1:0]);
      end
      OP_SCALE: begin
        num_r <= x1000(mul_p[NRW-1:0]);
      end
      OP_DIV_INIT: begin
        ovf_l <= (hi_l >= dt_ext);
        ovf_r <= (hi_r >= dt_ext);
        rem_l <= hi_l[31:0];
        rem_r <= hi_r[31:0];
        lo_l  <= num_l[QW-1:0];
        lo_r  <= num_r[QW-1:0];
        q_l   <= '0;
        q_r   <= '0;
      end
      OP_DIV_STEP: begin
        rem_l <= ge_l ? 32'(r2_l - dt33) : r2_l[31:0];
        rem_r <= ge_r ? 32'(r2_r - dt33) : r2_r[31:0];
        lo_l  <= lo_l << 1;
        lo_r  <= lo_r << 1;
        q_l   <= {q_l[QW-2:0], ge_l};
        q_r   <= {q_r[QW-2:0], ge_r};
      end
      OP_VEL: begin
        vl <= to_vel(neg_l, ovf_l, q_l[QW-1:SHIFT]);
        vr <= to_vel(neg_r, ovf_r, q_r[QW-1:SHIFT]);
      end
      OP_ERR: begin
        err <= sat32(64'(vr) - 64'(mul_p >>> 12));
      end
      OP_MUL_K: begin
        derr <= 33'(err) - 33'(last_error);
      end
      OP_MUL_B: begin
        pk <= mul_p[48:0];
      end
      OP_DV: begin
        dv <= sat32(pd_sum >>> 8);
      end
      OP_ADJ: begin
        vl <= sat32(64'(vl) - 64'(dv));
        vr <= sat32(64'(vr) + 64'(dv));
      end
      OP_PWM_R: begin
        pwm_l <= (vl == 32'sd0) ? 32'sd0 : sat32((64'(mul_p) >>> 16) + OFF_L);
      end
      OP_PWM_FIN: begin
        pwm_r <= (vr == 32'sd0) ? 32'sd0 : sat32((64'(mul_p) >>> 16) + OFF_R);
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/dbal_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dbal_ctrl #(
  parameter int FRACTION_BITS = dbal_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  dbal_pkg::dp_stat_t stat,
  output dbal_pkg::dp_cmd_t  cmd
);
  import dbal_pkg::*;

  localparam int QW    = 56 - FRACTION_BITS;
  localparam int CNT_W = $clog2(QW);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] div_cnt;
  logic [CNT_W-1:0] div_cnt_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      div_cnt   <= div_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    in_ready     = 1'b0;
    cmd          = '{op: OP_NONE, load_in: 1'b0, load_out: 1'b0};
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_LOAD;
        end
      end
      S_LOAD: begin
        if (stat.kind) begin
          cmd.op     = OP_DIFF;
          state_next = stat.fault ? S_MUL_C : S_MUL_L;
        end else begin
          cmd.op     = OP_REF;
          state_next = S_DONE;
        end
      end
      S_MUL_L: begin
        cmd.op     = OP_MUL_L;
        state_next = S_MUL_R;
      end
      S_MUL_R: begin
        cmd.op     = OP_MUL_R;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.op     = OP_SCALE;
        state_next = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.op       = OP_DIV_INIT;
        div_cnt_next = CNT_W'(QW - 1);
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (div_cnt == '0) begin
          state_next = S_VEL;
        end else begin
          div_cnt_next = div_cnt - 1'b1;
        end
      end
      S_VEL: begin
        cmd.op     = OP_VEL;
        state_next = S_MUL_C;
      end
      S_MUL_C: begin
        cmd.op     = OP_MUL_C;
        state_next = S_ERR;
      end
      S_ERR: begin
        cmd.op     = OP_ERR;
        state_next = S_MUL_K;
      end
      S_MUL_K: begin
        cmd.op     = OP_MUL_K;
        state_next = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.op     = OP_MUL_B;
        state_next = S_DV;
      end
      S_DV: begin
        cmd.op     = OP_DV;
        state_next = S_ADJ;
      end
      S_ADJ: begin
        cmd.op     = OP_ADJ;
        state_next = S_PWM_L;
      end
      S_PWM_L: begin
        cmd.op     = OP_PWM_L;
        state_next = S_PWM_R;
      end
      S_PWM_R: begin
        cmd.op     = OP_PWM_R;
        state_next = S_PWM_FIN;
      end
      S_PWM_FIN: begin
        cmd.op     = OP_PWM_FIN;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  a_accept_to_load: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_LOAD))
    else $error("accepted beat did not start processing");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result register overwritten before it was taken");

  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_cnt == '0) |=> (state == S_VEL))
    else $error("divider did not finish after its last step");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");

endmodule

`default_nettype wire

// ===== rtl/differential_drive_pd_balancer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Differential-drive PD balancer. Each input beat carries both wheel encoder
// counts and a millisecond timestamp. A beat with kind 0 stores them as the
// reference point and returns an all-zero result; a beat with kind 1 turns the
// count changes since that reference into wheel velocities (Q16.16 by default),
// runs a PD step on the error between the right velocity and ratio_c times the
// left one, shifts the two velocities apart by the correction, and maps each to
// a saturated drive value. A zero elapsed time raises time_fault and uses zero
// velocities. Every input beat yields exactly one result beat. The block works
// on one item at a time; a correction item spends most of its time in the
// bit-per-cycle divider that forms both wheel velocities side by side, while
// a correction with zero elapsed time skips the divider. One shared 34 x 27
// multiplier forms every product but the scaling by 1000, done with shifts.
// A finished result waits in an output register, so the next item is taken
// while it is still pending. Configuration writes go to registers 0 (gain_k),
// 1 (gain_b), 2 (ratio_c) and 3 (meters_per_count); other indexes are ignored.

module differential_drive_pd_balancer #(
  parameter int FRACTION_BITS = dbal_pkg::FRACTION_BITS_DEF,
  parameter int COUNT_WIDTH   = dbal_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dbal_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dbal_pkg::CFG_DATA_W-1:0] cfg_data,
  dbal_stream_if.sink                     sample,
  dbal_stream_if.source                   result
);
  import dbal_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller steps the datapath one op per cycle unless a handshake holds
  // it, and owns both handshakes; the datapath holds the configuration, the
  // reference point, divider lanes, shared multiplier and result register.
  dbal_ctrl #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (sample.ready),
    .out_valid(result.valid),
    .out_ready(result.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dbal_dp #(
    .FRACTION_BITS(FRACTION_BITS),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .item_in  (sample.data),
    .item_out (result.data)
  );

endmodule

`default_nettype wire
